FILE: design/nmt_pkg.sv
package nmt_pkg;

   // Table geometry and counter widths.
   localparam int TABLE_ENTRIES = 64;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   // External port allocation.
   localparam logic [15:0] PORT_BASE = 16'd1024;
   localparam logic [15:0] PORT_SPAN = 16'd64500;

   // Register reset values.
   localparam logic [15:0] IDLE_LIMIT_RESET = 16'd60;

   // Register indexes on the configuration port.
   localparam logic [0:0] CSR_EXTERNAL_ADDRESS = 1'b0;
   localparam logic [0:0] CSR_ICMP_IDLE_LIMIT  = 1'b1;

   // Flow kinds.
   localparam logic KIND_ICMP = 1'b0;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_MISS  = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      MODE_INSERT     = 2'd0,
      MODE_LOOKUP_IN  = 2'd1,
      MODE_LOOKUP_OUT = 2'd2,
      MODE_TICK       = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_HOLD
   } state_type;

   // Token that walks the cell chain, one cell per cycle.
   typedef struct packed {
      logic             active;
      mode_type         mode;
      logic [31:0]      addr;
      logic [15:0]      iport;
      logic [15:0]      oport;
      logic             kind;
      logic [31:0]      seq;
      logic [31:0]      now;
      logic [15:0]      limit;
      logic [15:0]      new_port;
      logic             hit;
      logic [31:0]      best_age;
      logic [31:0]      r_addr;
      logic [15:0]      r_iport;
      logic [15:0]      r_oport;
      logic             r_kind;
      logic [CNT_W-1:0] count;
   } token_type;

endpackage

FILE: design/nmt_req_if.sv
interface nmt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] inside_address;
   logic [15:0] inside_port;
   logic [15:0] outside_port;
   logic        flow_kind;

   modport source (output valid, mode, inside_address, inside_port, outside_port,
                   flow_kind, input ready);
   modport sink (input valid, mode, inside_address, inside_port, outside_port,
                 flow_kind, output ready);
endinterface

FILE: design/nmt_rsp_if.sv
interface nmt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] found_inside_address;
   logic [15:0] found_inside_port;
   logic [31:0] found_outside_address;
   logic [15:0] found_outside_port;
   logic        found_kind;
   logic [nmt_pkg::CNT_W-1:0] expired_count;

   modport source (output valid, status, found_inside_address, found_inside_port,
                   found_outside_address, found_outside_port, found_kind,
                   expired_count, input ready);
   modport sink (input valid, status, found_inside_address, found_inside_port,
                 found_outside_address, found_outside_port, found_kind,
                 expired_count, output ready);
endinterface

FILE: design/nmt_cell.sv
module nmt_cell (
   input  logic               clock,
   input  logic               reset,
   input  nmt_pkg::token_type tok_i,
   output nmt_pkg::token_type tok_o
);

   logic        valid_ff, valid_in;
   logic        kind_ff;
   logic [31:0] addr_ff;
   logic [15:0] iport_ff;
   logic [15:0] oport_ff;
   logic [31:0] stamp_ff;
   logic [31:0] order_ff;
   nmt_pkg::token_type tok_ff, tok_in;

   logic        is_lookup;
   logic        key_hit;
   logic [31:0] age;
   logic        take_lookup;
   logic        take_insert;
   logic        expire;

   // Match, placement and ageing decisions for the passing token.
   always_comb begin
      is_lookup = (tok_i.mode == nmt_pkg::MODE_LOOKUP_IN) ||
                  (tok_i.mode == nmt_pkg::MODE_LOOKUP_OUT);
      if (tok_i.mode == nmt_pkg::MODE_LOOKUP_OUT) begin
         key_hit = (oport_ff == tok_i.oport);
      end else begin
         key_hit = (addr_ff == tok_i.addr) && (iport_ff == tok_i.iport);
      end
      age = tok_i.seq - order_ff;
      take_lookup = tok_i.active && is_lookup && valid_ff && (kind_ff == tok_i.kind) &&
                    key_hit && (!tok_i.hit || (age < tok_i.best_age));
      take_insert = tok_i.active && (tok_i.mode == nmt_pkg::MODE_INSERT) &&
                    !tok_i.hit && !valid_ff;
      expire = tok_i.active && (tok_i.mode == nmt_pkg::MODE_TICK) && valid_ff &&
               (kind_ff == nmt_pkg::KIND_ICMP) &&
               ((tok_i.now - stamp_ff) > {16'd0, tok_i.limit});
   end

   // Updated token and valid bit.
   always_comb begin
      tok_in   = tok_i;
      valid_in = valid_ff;
      if (take_lookup) begin
         tok_in.hit      = 1'b1;
         tok_in.best_age = age;
         tok_in.r_addr   = addr_ff;
         tok_in.r_iport  = iport_ff;
         tok_in.r_oport  = oport_ff;
         tok_in.r_kind   = kind_ff;
      end
      if (take_insert) begin
         valid_in       = 1'b1;
         tok_in.hit     = 1'b1;
         tok_in.r_addr  = tok_i.addr;
         tok_in.r_iport = tok_i.iport;
         tok_in.r_oport = tok_i.new_port;
         tok_in.r_kind  = tok_i.kind;
      end
      if (expire) begin
         valid_in     = 1'b0;
         tok_in.count = tok_i.count + nmt_pkg::CNT_W'(1);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Slot contents and token payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff.active <= tok_in.active;
      end
      tok_ff.mode     <= tok_in.mode;
      tok_ff.addr     <= tok_in.addr;
      tok_ff.iport    <= tok_in.iport;
      tok_ff.oport    <= tok_in.oport;
      tok_ff.kind     <= tok_in.kind;
      tok_ff.seq      <= tok_in.seq;
      tok_ff.now      <= tok_in.now;
      tok_ff.limit    <= tok_in.limit;
      tok_ff.new_port <= tok_in.new_port;
      tok_ff.hit      <= tok_in.hit;
      tok_ff.best_age <= tok_in.best_age;
      tok_ff.r_addr   <= tok_in.r_addr;
      tok_ff.r_iport  <= tok_in.r_iport;
      tok_ff.r_oport  <= tok_in.r_oport;
      tok_ff.r_kind   <= tok_in.r_kind;
      tok_ff.count    <= tok_in.count;
      if (take_insert) begin
         kind_ff  <= tok_i.kind;
         addr_ff  <= tok_i.addr;
         iport_ff <= tok_i.iport;
         oport_ff <= tok_i.new_port;
         stamp_ff <= tok_i.now;
         order_ff <= tok_i.seq;
      end
   end

   assign tok_o = tok_ff;

endmodule

FILE: design/nat_mapping_table.sv
// NAT mapping table built as a chain of TABLE_ENTRIES slot cells. Each request
// becomes a token that enters the chain and moves one cell per cycle; each
// cell holds one mapping and places, matches or ages it as the token passes.
// The result is offered once the token has left the end of the cell chain, and
// only one transaction is in the chain at a time; the next is accepted in the
// cycle after the result has been taken.
// Insert takes the lowest free cell, lookups return the most recently
// inserted match, and a tick drops idle ICMP mappings.
// Valid bits are cleared by reset; no clearing pass is needed.
module nat_mapping_table (
   input  logic              clock,
   input  logic              reset,
   nmt_req_if.sink           req,
   nmt_rsp_if.source         rsp,
   input  logic              csr_write_enable,
   input  logic [0:0]        csr_index,
   input  logic [31:0]       csr_write_data
);

   nmt_pkg::state_type state_ff, state_in;
   nmt_pkg::token_type head_ff, head_in;
   nmt_pkg::token_type link [nmt_pkg::TABLE_ENTRIES+1];
   nmt_pkg::token_type tail;

   logic [31:0] ext_addr_ff;
   logic [15:0] limit_ff;
   logic [31:0] seq_ff, seq_in;
   logic [15:0] port_ff, port_in;
   logic [31:0] sec_ff, sec_in;

   logic        rsp_valid_ff;
   logic [1:0]  status_ff, status_in;
   logic [31:0] r_addr_ff, r_addr_in;
   logic [15:0] r_iport_ff, r_iport_in;
   logic [15:0] r_oport_ff, r_oport_in;
   logic        r_kind_ff, r_kind_in;
   logic [nmt_pkg::CNT_W-1:0] count_ff, count_in;
   logic        r_hit_ff;

   logic        accept;
   logic        finish;
   logic [15:0] port_next;

   assign accept = req.valid && req.ready;
   assign tail   = link[nmt_pkg::TABLE_ENTRIES];
   assign finish = tail.active && (state_ff == nmt_pkg::ST_SWEEP);

   // Cell chain.
   assign link[0] = head_ff;
   for (genvar g = 0; g < nmt_pkg::TABLE_ENTRIES; g++) begin : g_cell
      nmt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .tok_i (link[g]),
         .tok_o (link[g+1])
      );
   end

   // Next external port, wrapping within the port span.
   assign port_next = (port_ff + 16'd1 >= nmt_pkg::PORT_SPAN) ? 16'd0 : port_ff + 16'd1;

   // Sequencer, token launch, result capture and global counters.
   always_comb begin
      state_in   = state_ff;
      seq_in     = seq_ff;
      port_in    = port_ff;
      sec_in     = sec_ff;
      status_in  = status_ff;
      r_addr_in  = r_addr_ff;
      r_iport_in = r_iport_ff;
      r_oport_in = r_oport_ff;
      r_kind_in  = r_kind_ff;
      count_in   = count_ff;

      head_in          = '0;
      head_in.active   = accept;
      head_in.mode     = nmt_pkg::mode_type'(req.mode);
      head_in.addr     = req.inside_address;
      head_in.iport    = req.inside_port;
      head_in.oport    = req.outside_port;
      head_in.kind     = req.flow_kind;
      head_in.seq      = seq_ff;
      // A tick ages against the advanced second; an insert stamps the current one.
      head_in.now      = (nmt_pkg::mode_type'(req.mode) == nmt_pkg::MODE_TICK)
                         ? sec_ff + 32'd1 : sec_ff;
      head_in.limit    = limit_ff;
      head_in.new_port = port_ff + nmt_pkg::PORT_BASE;

      unique case (state_ff)
         nmt_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = nmt_pkg::ST_SWEEP;
               if (nmt_pkg::mode_type'(req.mode) == nmt_pkg::MODE_TICK) begin
                  sec_in = sec_ff + 32'd1;
               end
            end
         end
         nmt_pkg::ST_SWEEP: begin
            if (finish) begin
               state_in   = nmt_pkg::ST_HOLD;
               r_addr_in  = '0;
               r_iport_in = '0;
               r_oport_in = '0;
               r_kind_in  = 1'b0;
               count_in   = '0;
               status_in  = nmt_pkg::STATUS_OK;
               if (tail.mode == nmt_pkg::MODE_TICK) begin
                  count_in = tail.count;
               end else if (tail.hit) begin
                  r_addr_in  = tail.r_addr;
                  r_iport_in = tail.r_iport;
                  r_oport_in = tail.r_oport;
                  r_kind_in  = tail.r_kind;
                  if (tail.mode == nmt_pkg::MODE_INSERT) begin
                     seq_in  = seq_ff + 32'd1;
                     port_in = port_next;
                  end
               end else if (tail.mode == nmt_pkg::MODE_INSERT) begin
                  status_in = nmt_pkg::STATUS_FULL;
               end else begin
                  status_in = nmt_pkg::STATUS_MISS;
               end
            end
         end
         nmt_pkg::ST_HOLD: begin
            if (rsp.ready) begin
               state_in = nmt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nmt_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= nmt_pkg::ST_IDLE;
         seq_ff         <= '0;
         port_ff        <= '0;
         sec_ff         <= '0;
         ext_addr_ff    <= '0;
         limit_ff       <= nmt_pkg::IDLE_LIMIT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         seq_ff         <= seq_in;
         port_ff        <= port_in;
         sec_ff         <= sec_in;
         rsp_valid_ff   <= (state_in == nmt_pkg::ST_HOLD);
         if (csr_write_enable) begin
            unique case (csr_index)
               nmt_pkg::CSR_EXTERNAL_ADDRESS: ext_addr_ff <= csr_write_data;
               nmt_pkg::CSR_ICMP_IDLE_LIMIT:  limit_ff    <= csr_write_data[15:0];
               default: ;
            endcase
         end
      end
   end

   // Token payload and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.active <= 1'b0;
      end else begin
         head_ff.active <= head_in.active;
      end
      head_ff.mode     <= head_in.mode;
      head_ff.addr     <= head_in.addr;
      head_ff.iport    <= head_in.iport;
      head_ff.oport    <= head_in.oport;
      head_ff.kind     <= head_in.kind;
      head_ff.seq      <= head_in.seq;
      head_ff.now      <= head_in.now;
      head_ff.limit    <= head_in.limit;
      head_ff.new_port <= head_in.new_port;
      head_ff.hit      <= head_in.hit;
      head_ff.best_age <= head_in.best_age;
      head_ff.r_addr   <= head_in.r_addr;
      head_ff.r_iport  <= head_in.r_iport;
      head_ff.r_oport  <= head_in.r_oport;
      head_ff.r_kind   <= head_in.r_kind;
      head_ff.count    <= head_in.count;
      status_ff        <= status_in;
      r_addr_ff        <= r_addr_in;
      r_iport_ff       <= r_iport_in;
      r_oport_ff       <= r_oport_in;
      r_kind_ff        <= r_kind_in;
      count_ff         <= count_in;
   end

   // Remembers whether the result reports a mapping.
   always_ff @(posedge clock) begin
      if (finish) begin
         r_hit_ff <= tail.hit && (tail.mode != nmt_pkg::MODE_TICK);
      end
   end

   // Channel outputs.
   assign req.ready                 = (state_ff == nmt_pkg::ST_IDLE);
   assign rsp.valid                 = rsp_valid_ff;
   assign rsp.status                = status_ff;
   assign rsp.found_inside_address  = r_addr_ff;
   assign rsp.found_inside_port     = r_iport_ff;
   assign rsp.found_outside_address = r_hit_ff ? ext_addr_ff : 32'd0;
   assign rsp.found_outside_port    = r_oport_ff;
   assign rsp.found_kind            = r_kind_ff;
   assign rsp.expired_count         = count_ff;

   // A result on offer blocks new transactions.
   assert property (@(posedge clock) disable iff (reset) rsp.valid |-> !req.ready)
      else $error("request accepted while a result is pending");

   // A token leaves the chain only while a sweep is running.
   assert property (@(posedge clock) disable iff (reset)
                    tail.active |-> state_ff == nmt_pkg::ST_SWEEP)
      else $error("token left the chain outside a sweep");

   // The port counter stays inside its span.
   assert property (@(posedge clock) disable iff (reset) port_ff < nmt_pkg::PORT_SPAN)
      else $error("port counter out of range");

   // A tick never removes more entries than the table holds.
   assert property (@(posedge clock) disable iff (reset)
                    rsp.valid |-> count_ff <= nmt_pkg::CNT_W'(nmt_pkg::TABLE_ENTRIES))
      else $error("expired count exceeds table size");

endmodule

FILE: dv/nat_mapping_table_test.sv
module nat_mapping_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   // One request as the driver presents it.
   typedef struct packed {
      nmt_pkg::mode_type mode;
      logic [31:0] inside_address;
      logic [15:0] inside_port;
      logic [15:0] outside_port;
      logic        flow_kind;
   } request_type;

   // One response as the block returns it.
   typedef struct packed {
      logic [1:0]       status;
      logic [31:0]      inside_address;
      logic [15:0]      inside_port;
      logic [31:0]      outside_address;
      logic [15:0]      outside_port;
      logic             kind;
      logic [nmt_pkg::CNT_W-1:0] expired;
   } response_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [0:0] csr_index;
   logic [31:0] csr_write_data;

   nmt_req_if req ();
   nmt_rsp_if rsp ();

   nat_mapping_table dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Shadow of the translation table.
   logic        map_valid [nmt_pkg::TABLE_ENTRIES];
   logic        map_kind [nmt_pkg::TABLE_ENTRIES];
   logic [31:0] map_inside_address [nmt_pkg::TABLE_ENTRIES];
   logic [15:0] map_inside_port [nmt_pkg::TABLE_ENTRIES];
   logic [15:0] map_outside_port [nmt_pkg::TABLE_ENTRIES];
   logic [31:0] map_stamp [nmt_pkg::TABLE_ENTRIES];
   logic [31:0] map_order [nmt_pkg::TABLE_ENTRIES];
   logic [31:0] next_sequence;
   logic [15:0] next_port;
   logic [31:0] clock_seconds;
   logic [31:0] public_address;
   logic [15:0] idle_limit;

   request_type  pending_requests[$];
   response_type expected_responses[$];
   int send_idle_pct;
   int take_idle_pct;
   int error_count;
   int response_count;
   int insert_count, full_count, miss_count, hit_count, expired_total;

   // Reports one mismatch and counts it.
   task automatic report_error(input string what, input logic [63:0] got,
                               input logic [63:0] want);
      $display("ERROR at %0t: %s got %0h expected %0h", $time, what, got, want);
      error_count++;
   endtask

   // Fills a response from one table entry.
   function automatic response_type entry_response(input int s);
      response_type r;
      r = '0;
      r.status = nmt_pkg::STATUS_OK;
      r.inside_address = map_inside_address[s];
      r.inside_port = map_inside_port[s];
      r.outside_address = public_address;
      r.outside_port = map_outside_port[s];
      r.kind = map_kind[s];
      return r;
   endfunction

   // Applies one accepted request to the shadow table and returns the response.
   function automatic response_type translate(input request_type q);
      response_type r;
      int found;
      logic [31:0] best_age;
      logic [31:0] age;
      logic hit;
      int removed;
      r = '0;
      found = -1;
      best_age = '0;
      removed = 0;
      case (q.mode)
         nmt_pkg::MODE_INSERT: begin
            for (int s = 0; s < nmt_pkg::TABLE_ENTRIES; s++) begin
               if (!map_valid[s] && found < 0) found = s;
            end
            if (found < 0) begin
               r.status = nmt_pkg::STATUS_FULL;
               full_count++;
            end else begin
               map_valid[found] = 1'b1;
               map_kind[found] = q.flow_kind;
               map_inside_address[found] = q.inside_address;
               map_inside_port[found] = q.inside_port;
               map_outside_port[found] = next_port + nmt_pkg::PORT_BASE;
               map_stamp[found] = clock_seconds;
               map_order[found] = next_sequence;
               next_sequence++;
               next_port = 16'((32'(next_port) + 1) % 32'(nmt_pkg::PORT_SPAN));
               r = entry_response(found);
               insert_count++;
            end
         end
         nmt_pkg::MODE_LOOKUP_IN, nmt_pkg::MODE_LOOKUP_OUT: begin
            for (int s = 0; s < nmt_pkg::TABLE_ENTRIES; s++) begin
               if (map_valid[s] && map_kind[s] == q.flow_kind) begin
                  if (q.mode == nmt_pkg::MODE_LOOKUP_OUT)
                     hit = map_outside_port[s] == q.outside_port;
                  else
                     hit = map_inside_address[s] == q.inside_address &&
                           map_inside_port[s] == q.inside_port;
                  age = next_sequence - map_order[s];
                  if (hit && (found < 0 || age < best_age)) begin
                     found = s;
                     best_age = age;
                  end
               end
            end
            if (found < 0) begin
               r.status = nmt_pkg::STATUS_MISS;
               miss_count++;
            end else begin
               r = entry_response(found);
               hit_count++;
            end
         end
         default: begin
            clock_seconds++;
            for (int s = 0; s < nmt_pkg::TABLE_ENTRIES; s++) begin
               if (map_valid[s] && map_kind[s] == nmt_pkg::KIND_ICMP &&
                   (clock_seconds - map_stamp[s]) > 32'(idle_limit)) begin
                  map_valid[s] = 1'b0;
                  removed++;
               end
            end
            r.status = nmt_pkg::STATUS_OK;
            r.expired = nmt_pkg::CNT_W'(removed);
            expired_total += removed;
         end
      endcase
      return r;
   endfunction

   // Clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Driver: presents queued requests, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (req.valid && req.ready)
            void'(pending_requests.pop_front());
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            request_type q;
            q = pending_requests[0];
            req.valid <= 1'b1;
            req.mode <= q.mode;
            req.inside_address <= q.inside_address;
            req.inside_port <= q.inside_port;
            req.outside_port <= q.outside_port;
            req.flow_kind <= q.flow_kind;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Predicts at acceptance time so table state follows the block's order.
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         request_type q;
         q.mode = nmt_pkg::mode_type'(req.mode);
         q.inside_address = req.inside_address;
         q.inside_port = req.inside_port;
         q.outside_port = req.outside_port;
         q.flow_kind = req.flow_kind;
         expected_responses.push_back(translate(q));
      end
   end

   // Monitor: random back pressure and field-by-field checking.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            response_count++;
            if (expected_responses.size() == 0) begin
               report_error("unexpected response status", 64'(rsp.status), 0);
            end else begin
               response_type e;
               e = expected_responses.pop_front();
               if (rsp.status !== e.status)
                  report_error("status", 64'(rsp.status), 64'(e.status));
               if (rsp.found_inside_address !== e.inside_address)
                  report_error("inside address", 64'(rsp.found_inside_address),
                               64'(e.inside_address));
               if (rsp.found_inside_port !== e.inside_port)
                  report_error("inside port", 64'(rsp.found_inside_port),
                               64'(e.inside_port));
               if (rsp.found_outside_address !== e.outside_address)
                  report_error("outside address", 64'(rsp.found_outside_address),
                               64'(e.outside_address));
               if (rsp.found_outside_port !== e.outside_port)
                  report_error("outside port", 64'(rsp.found_outside_port),
                               64'(e.outside_port));
               if (rsp.found_kind !== e.kind)
                  report_error("kind", 64'(rsp.found_kind), 64'(e.kind));
               if (rsp.expired_count !== e.expired)
                  report_error("expired count", 64'(rsp.expired_count),
                               64'(e.expired));
            end
         end
         rsp.ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // Builds one request.
   function automatic request_type make_request(input nmt_pkg::mode_type m,
                                                input logic [31:0] a,
                                                input logic [15:0] ip,
                                                input logic [15:0] op, input logic k);
      request_type q;
      q.mode = m;
      q.inside_address = a;
      q.inside_port = ip;
      q.outside_port = op;
      q.flow_kind = k;
      return q;
   endfunction

   // Waits until every queued transaction has been answered, then settles.
   task automatic drain();
      while (pending_requests.size() != 0)
         @(posedge clock);
      // The last acceptance has been predicted by the next edge.
      @(posedge clock);
      while (expected_responses.size() != 0)
         @(posedge clock);
      repeat (nmt_pkg::TABLE_ENTRIES + 8) @(posedge clock);
   endtask

   task automatic write_register(input logic [0:0] index, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == nmt_pkg::CSR_EXTERNAL_ADDRESS) public_address = value;
      else idle_limit = value[15:0];
   endtask

   // Random traffic mostly built around a small pool of eight addresses and ports.
   task automatic random_phase(input int count);
      logic [31:0] addr_pool [8];
      logic [15:0] port_pool [8];
      int p;
      nmt_pkg::mode_type m;
      for (int i = 0; i < 8; i++) begin
         addr_pool[i] = $urandom;
         port_pool[i] = 16'($urandom);
      end
      for (int i = 0; i < count; i++) begin
         p = $urandom_range(7);
         case ($urandom_range(9))
            0, 1, 2: m = nmt_pkg::MODE_INSERT;
            3, 4: m = nmt_pkg::MODE_LOOKUP_IN;
            5, 6: m = nmt_pkg::MODE_LOOKUP_OUT;
            default: m = nmt_pkg::MODE_TICK;
         endcase
         if ($urandom_range(9) == 0)
            pending_requests.push_back(make_request(m, $urandom, 16'($urandom),
                                                    16'($urandom), 1'($urandom)));
         else
            pending_requests.push_back(make_request(m, addr_pool[p], port_pool[p],
               16'(nmt_pkg::PORT_BASE + (next_port + 16'($urandom_range(80)))
                   % nmt_pkg::PORT_SPAN - 16'($urandom_range(80))), 1'($urandom)));
         // Keep the queue short so random choices track the table.
         while (pending_requests.size() > 4) @(posedge clock);
      end
   endtask

   initial begin
      error_count = 0;
      response_count = 0;
      insert_count = 0; full_count = 0; miss_count = 0; hit_count = 0;
      expired_total = 0;
      for (int s = 0; s < nmt_pkg::TABLE_ENTRIES; s++) map_valid[s] = 1'b0;
      next_sequence = '0;
      next_port = '0;
      clock_seconds = '0;
      public_address = '0;
      idle_limit = nmt_pkg::IDLE_LIMIT_RESET;
      send_idle_pct = 17;
      take_idle_pct = 87;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req.valid = 1'b0;
      req.mode = '0;
      req.inside_address = '0;
      req.inside_port = '0;
      req.outside_port = '0;
      req.flow_kind = 1'b0;
      rsp.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every operation, misses, ageing and a full table.
      write_register(nmt_pkg::CSR_EXTERNAL_ADDRESS, 32'hFFFF_FFFF);
      write_register(nmt_pkg::CSR_ICMP_IDLE_LIMIT, 32'd1);
      pending_requests.push_back(make_request(nmt_pkg::MODE_LOOKUP_IN, 32'h0, 16'h0,
                                              16'h0, 1'b0));
      pending_requests.push_back(make_request(nmt_pkg::MODE_INSERT, 32'hFFFF_FFFF,
                                              16'hFFFF, 16'h0, 1'b0));
      pending_requests.push_back(make_request(nmt_pkg::MODE_INSERT, 32'h0, 16'h0,
                                              16'hFFFF, 1'b1));
      pending_requests.push_back(make_request(nmt_pkg::MODE_INSERT, 32'hFFFF_FFFF,
                                              16'hFFFF, 16'h0, 1'b0));
      pending_requests.push_back(make_request(nmt_pkg::MODE_LOOKUP_IN, 32'hFFFF_FFFF,
                                              16'hFFFF, 16'h0, 1'b0));
      pending_requests.push_back(make_request(nmt_pkg::MODE_LOOKUP_IN, 32'h0, 16'h0,
                                              16'h0, 1'b1));
      pending_requests.push_back(make_request(nmt_pkg::MODE_LOOKUP_OUT, 32'h0, 16'h0,
                                              16'd1025, 1'b1));
      pending_requests.push_back(make_request(nmt_pkg::MODE_LOOKUP_OUT, 32'h0, 16'h0,
                                              16'd1025, 1'b0));
      pending_requests.push_back(make_request(nmt_pkg::MODE_LOOKUP_OUT, 32'hFFFF_FFFF,
                                              16'hFFFF, 16'hFFFF, 1'b1));
      pending_requests.push_back(make_request(nmt_pkg::MODE_TICK, 32'h0, 16'h0,
                                              16'h0, 1'b0));
      pending_requests.push_back(make_request(nmt_pkg::MODE_TICK, 32'hFFFF_FFFF,
                                              16'hFFFF, 16'hFFFF, 1'b1));
      pending_requests.push_back(make_request(nmt_pkg::MODE_LOOKUP_IN, 32'hFFFF_FFFF,
                                              16'hFFFF, 16'h0, 1'b0));
      drain();
      write_register(nmt_pkg::CSR_ICMP_IDLE_LIMIT, 32'h0000_FFFF);
      write_register(nmt_pkg::CSR_EXTERNAL_ADDRESS, 32'h0);
      for (int i = 0; i < 66; i++)
         pending_requests.push_back(make_request(nmt_pkg::MODE_INSERT, 32'(i), 16'(i),
                                                 16'h0, 1'(i)));
      pending_requests.push_back(make_request(nmt_pkg::MODE_TICK, 32'h0, 16'h0,
                                              16'h0, 1'b0));
      drain();

      // Random phases with different idling and register settings.
      write_register(nmt_pkg::CSR_ICMP_IDLE_LIMIT, 32'd0);
      pending_requests.push_back(make_request(nmt_pkg::MODE_TICK, 32'h0, 16'h0,
                                              16'h0, 1'b0));
      random_phase(450);
      drain();
      send_idle_pct = 87;
      take_idle_pct = 17;
      write_register(nmt_pkg::CSR_EXTERNAL_ADDRESS, $urandom);
      write_register(nmt_pkg::CSR_ICMP_IDLE_LIMIT, 32'($urandom_range(1, 6)));
      random_phase(450);
      drain();
      send_idle_pct = 0;
      take_idle_pct = 0;
      write_register(nmt_pkg::CSR_EXTERNAL_ADDRESS, $urandom);
      write_register(nmt_pkg::CSR_ICMP_IDLE_LIMIT, 32'($urandom_range(2, 12)));
      random_phase(450);
      drain();

      $display("Checked %0d responses: %0d inserts, %0d full, %0d hits, %0d misses.",
               response_count, insert_count, full_count, hit_count, miss_count);
      $display("Ticks aged out %0d ICMP mappings across several idle limits.",
               expired_total);
      if (error_count == 0) begin
         $display("** nat_mapping_table: PASSED **");
      end else begin
         $display("** nat_mapping_table: FAILED **");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5ms;
      $display("** nat_mapping_table: FAILED **");
      $finish;
   end

endmodule

FILE: filelist.f
design/nmt_pkg.sv
design/nmt_req_if.sv
design/nmt_rsp_if.sv
design/nmt_cell.sv
design/nat_mapping_table.sv
dv/nat_mapping_table_test.sv
